/* design/nabf_pkg.sv */
// ----------------------------------------------------------------------------
// nabf_pkg
// shared widths, types and register indexes of the neighbor area box filter
// ----------------------------------------------------------------------------
package nabf_pkg;

  localparam int unsigned PosW      = 12;
  localparam int unsigned SideW     = 13;
  localparam int unsigned AreaW     = 25;
  localparam int unsigned LimitW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 25;
  localparam int unsigned MaxSide   = 4096;
  localparam int unsigned QueueDepth = 2;

  localparam logic [LimitW-1:0] RatioLimitRst = LimitW'(5);
  localparam logic [AreaW-1:0]  MinAreaRst    = AreaW'(30);

  localparam logic [CfgIdxW-1:0] CfgRatioLimit = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMinArea    = CfgIdxW'(1);

  typedef struct packed {
    logic [PosW-1:0]  x;
    logic [PosW-1:0]  y;
    logic [SideW-1:0] w;
    logic [SideW-1:0] h;
  } box_t;

  typedef struct packed {
    box_t             box;
    logic [AreaW-1:0] area;
    logic             last;
  } entry_t;

  typedef struct packed {
    box_t box;
    logic keep;
    logic last_of_item;
  } res_t;

endpackage

/* design/nabf_if.sv */
// ----------------------------------------------------------------------------
// nabf channel interfaces
// box input, result output and register write channels
// ----------------------------------------------------------------------------
interface nabf_box_if;
  logic                      valid;
  logic                      ready;
  logic [nabf_pkg::PosW-1:0]  box_x;
  logic [nabf_pkg::PosW-1:0]  box_y;
  logic [nabf_pkg::SideW-1:0] box_width;
  logic [nabf_pkg::SideW-1:0] box_height;
  logic                      list_last;

  modport source (output valid, box_x, box_y, box_width, box_height, list_last,
                  input ready);
  modport sink (input valid, box_x, box_y, box_width, box_height, list_last,
                output ready);
endinterface

interface nabf_res_if;
  logic                      valid;
  logic                      ready;
  logic [nabf_pkg::PosW-1:0]  out_x;
  logic [nabf_pkg::PosW-1:0]  out_y;
  logic [nabf_pkg::SideW-1:0] out_width;
  logic [nabf_pkg::SideW-1:0] out_height;
  logic                      keep;
  logic                      last_of_item;

  modport source (output valid, out_x, out_y, out_width, out_height, keep, last_of_item,
                  input ready);
  modport sink (input valid, out_x, out_y, out_width, out_height, keep, last_of_item,
                output ready);
endinterface

interface nabf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [nabf_pkg::CfgIdxW-1:0]  index;
  logic [nabf_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/nabf_front.sv */
// ----------------------------------------------------------------------------
// nabf_front
// input register: takes a box and registers it with the product of its clamped sides as its area
// ----------------------------------------------------------------------------
module nabf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  nabf_box_if.sink          box_i,
  output logic              push_o,
  output nabf_pkg::entry_t  entry_o,
  input  logic              full_i
);

  logic             valid_q, valid_d;
  nabf_pkg::entry_t entry_q, entry_d;
  logic [nabf_pkg::SideW-1:0]   w_clamp, h_clamp;
  logic [2*nabf_pkg::SideW-1:0] area_full;
  logic             take;

  localparam logic [nabf_pkg::SideW-1:0] MaxSideC = nabf_pkg::SideW'(nabf_pkg::MaxSide);

  assign push_o      = valid_q && !full_i;
  assign box_i.ready = !valid_q || !full_i;
  assign take        = box_i.valid && box_i.ready;
  assign entry_o     = entry_q;

  always_comb begin
    w_clamp   = (box_i.box_width > MaxSideC) ? MaxSideC : box_i.box_width;
    h_clamp   = (box_i.box_height > MaxSideC) ? MaxSideC : box_i.box_height;
    area_full = (2*nabf_pkg::SideW)'(w_clamp) * (2*nabf_pkg::SideW)'(h_clamp);
    entry_d          = entry_q;
    valid_d          = valid_q;
    if (take) begin
      entry_d.box.x  = box_i.box_x;
      entry_d.box.y  = box_i.box_y;
      entry_d.box.w  = box_i.box_width;
      entry_d.box.h  = box_i.box_height;
      entry_d.area   = area_full[nabf_pkg::AreaW-1:0];
      entry_d.last   = box_i.list_last;
      valid_d        = 1'b1;
    end else if (push_o) begin
      valid_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* design/nabf_queue.sv */
// ----------------------------------------------------------------------------
// nabf_queue
// short fifo between the front register and the decision stage
// ----------------------------------------------------------------------------
module nabf_queue #(
  parameter int unsigned Depth = nabf_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nabf_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output nabf_pkg::entry_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  nabf_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntMax);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
`endif

endmodule

/* design/nabf_back.sv */
// ----------------------------------------------------------------------------
// nabf_back
// holds one box, decides keep against its neighbors and drives the results
// ----------------------------------------------------------------------------
module nabf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  nabf_cfg_if.sink          cfg_i,
  input  logic              valid_i,
  input  nabf_pkg::entry_t  head_i,
  output logic              pop_o,
  nabf_res_if.source        res_o
);

  localparam int unsigned ProdW = nabf_pkg::AreaW + nabf_pkg::LimitW;

  logic [nabf_pkg::LimitW-1:0] limit_q;
  logic [nabf_pkg::AreaW-1:0]  min_area_q;

  nabf_pkg::box_t             held_box_q, held_box_d;
  logic [nabf_pkg::AreaW-1:0] held_area_q, held_area_d;
  logic                       held_prev_q, held_prev_d;
  logic                       held_valid_q, held_valid_d;

  nabf_pkg::res_t out_q, out_d, pend_q, pend_d;
  logic           out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  logic           out_free, keep_held, new_prev;

  function automatic logic agrees(input logic [nabf_pkg::AreaW-1:0]  own,
                                  input logic [nabf_pkg::AreaW-1:0]  other,
                                  input logic [nabf_pkg::LimitW-1:0] lim,
                                  input logic [nabf_pkg::AreaW-1:0]  min_a);
    logic [ProdW-1:0] lim_own, lim_other;
    lim_own   = ProdW'(lim) * ProdW'(own);
    lim_other = ProdW'(lim) * ProdW'(other);
    return (own != '0) && (other != '0) && (ProdW'(own) < lim_other) &&
           (ProdW'(other) < lim_own) && (own >= min_a);
  endfunction

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= nabf_pkg::RatioLimitRst;
      min_area_q <= nabf_pkg::MinAreaRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        nabf_pkg::CfgRatioLimit: limit_q    <= cfg_i.data[nabf_pkg::LimitW-1:0];
        nabf_pkg::CfgMinArea:    min_area_q <= cfg_i.data[nabf_pkg::AreaW-1:0];
        default: ;
      endcase
    end
  end

  // decision
  assign out_free  = !out_valid_q || res_o.ready;
  assign pop_o     = valid_i && out_free && !pend_valid_q;
  assign keep_held = held_prev_q || agrees(held_area_q, head_i.area, limit_q, min_area_q);
  assign new_prev  = agrees(head_i.area, held_area_q, limit_q, min_area_q);

  always_comb begin
    held_box_d   = held_box_q;
    held_area_d  = held_area_q;
    held_prev_d  = held_prev_q;
    held_valid_d = held_valid_q;
    out_d        = out_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    if (out_free && pend_valid_q) begin
      out_d        = pend_q;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end else if (pop_o) begin
      if (!held_valid_q) begin
        if (head_i.last) begin
          out_d       = '{box: head_i.box, keep: 1'b1, last_of_item: 1'b1};
          out_valid_d = 1'b1;
        end else begin
          held_box_d   = head_i.box;
          held_area_d  = head_i.area;
          held_prev_d  = 1'b0;
          held_valid_d = 1'b1;
        end
      end else begin
        out_d       = '{box: held_box_q, keep: keep_held, last_of_item: !head_i.last};
        out_valid_d = 1'b1;
        if (head_i.last) begin
          pend_d       = '{box: head_i.box, keep: new_prev, last_of_item: 1'b1};
          pend_valid_d = 1'b1;
          held_valid_d = 1'b0;
        end else begin
          held_box_d  = head_i.box;
          held_area_d = head_i.area;
          held_prev_d = new_prev;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_prev_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      held_prev_q  <= held_prev_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_box_q  <= held_box_d;
    held_area_q <= held_area_d;
    out_q       <= out_d;
    pend_q      <= pend_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.out_x        = out_q.box.x;
  assign res_o.out_y        = out_q.box.y;
  assign res_o.out_width    = out_q.box.w;
  assign res_o.out_height   = out_q.box.h;
  assign res_o.keep         = out_q.keep;
  assign res_o.last_of_item = out_q.last_of_item;

`ifndef SYNTHESIS
  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q) else $error("second result without first");
  a_pair_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && held_valid_q && head_i.last) |=>
      (pend_valid_q && out_valid_q && !out_q.last_of_item && !held_valid_q))
    else $error("closing box did not queue two results");
  a_first_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !held_valid_q && !head_i.last) |=> (held_valid_q && !held_prev_q))
    else $error("opening box not held");
`endif

endmodule

/* design/neighbor_area_box_filter.sv */
// ----------------------------------------------------------------------------
// neighbor_area_box_filter
// keeps or drops each box of a list by comparing its area with its neighbors
// ----------------------------------------------------------------------------
// channels: box_i takes one box per item with list_last on the final box,
// res_o returns each box with its keep flag, one box late, and cfg_i writes
// the ratio limit (index 0) and the minimum area (index 1); the user must
// write them only while idle; the block does not enforce it. a box is
// decided when the next box of its list arrives; a closing box yields two
// results, the held box and then itself, with last_of_item set on the
// second. a one-box list returns its box kept.
// path: a box passes the input register and the two-entry queue in front of
// the decision stage, which writes its result into the output register.
// throughput: one box per cycle within a list while results drain; a closing
// box that meets a held box stalls the decision stage while its second
// result moves to the output register.
// reset: nothing held, queue empty, ratio limit 5, minimum area 30.
// a stalled receiver holds the output register; the queue and input register
// fill, then box_i.ready drops until results move again.
// ----------------------------------------------------------------------------
module neighbor_area_box_filter #(
  parameter int unsigned QueueDepth = nabf_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nabf_box_if.sink   box_i,
  nabf_cfg_if.sink   cfg_i,
  nabf_res_if.source res_o
);

  logic             push, full, pop, head_valid;
  nabf_pkg::entry_t entry, head;

  nabf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .box_i   (box_i),
    .push_o  (push),
    .entry_o (entry),
    .full_i  (full)
  );

  nabf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  nabf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .valid_i (head_valid),
    .head_i  (head),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

/* bench/neighbor_area_box_filter_tb.sv */
// ----------------------------------------------------------------------------
// neighbor_area_box_filter_tb
// streams box lists through the filter under several ratio limit and minimum
// area settings and checks every decided box against a cycle-free model of
// the neighbor agreement rule; sender gaps and receiver stalls vary by phase
// ----------------------------------------------------------------------------

class box_decision_board;

  nabf_pkg::res_t                     expected_q[$];
  nabf_pkg::box_t                     held_box;
  logic [nabf_pkg::AreaW-1:0]         held_area;
  bit                                 held_agrees_prev;
  bit                                 held_valid;
  logic [nabf_pkg::LimitW-1:0]        ratio_limit;
  logic [nabf_pkg::AreaW-1:0]         min_area;
  int unsigned                        mismatches;
  int unsigned                        checked;
  int unsigned                        kept;

  function new();
    held_box         = '0;
    held_area        = '0;
    held_agrees_prev = 1'b0;
    held_valid       = 1'b0;
    ratio_limit      = nabf_pkg::RatioLimitRst;
    min_area         = nabf_pkg::MinAreaRst;
    mismatches       = 0;
    checked          = 0;
    kept             = 0;
  endfunction

  function void write_reg(logic [nabf_pkg::CfgIdxW-1:0] idx,
                          logic [nabf_pkg::CfgDataW-1:0] data);
    case (idx)
      nabf_pkg::CfgRatioLimit: ratio_limit = data[nabf_pkg::LimitW-1:0];
      nabf_pkg::CfgMinArea:    min_area    = data[nabf_pkg::AreaW-1:0];
      default: ;
    endcase
  endfunction

  function logic [nabf_pkg::AreaW-1:0] box_area(nabf_pkg::box_t b);
    longint unsigned w;
    longint unsigned h;
    w = (b.w > nabf_pkg::MaxSide) ? nabf_pkg::MaxSide : b.w;
    h = (b.h > nabf_pkg::MaxSide) ? nabf_pkg::MaxSide : b.h;
    return nabf_pkg::AreaW'(w * h);
  endfunction

  function bit agrees(longint unsigned own, longint unsigned other);
    longint unsigned lim;
    lim = ratio_limit;
    if (own == 0 || other == 0) return 1'b0;
    if (own >= lim * other) return 1'b0;
    if (other >= lim * own) return 1'b0;
    return own >= min_area;
  endfunction

  function void push_result(nabf_pkg::box_t b, bit keep, bit last);
    nabf_pkg::res_t r;
    r.box          = b;
    r.keep         = keep;
    r.last_of_item = last;
    expected_q = {expected_q, r};
  endfunction

  function void note_box(nabf_pkg::box_t b, bit last);
    logic [nabf_pkg::AreaW-1:0] area;
    bit                         new_agrees_prev;
    area = box_area(b);
    if (!held_valid) begin
      if (last) begin
        push_result(b, 1'b1, 1'b1);
      end else begin
        held_box         = b;
        held_area        = area;
        held_agrees_prev = 1'b0;
        held_valid       = 1'b1;
      end
      return;
    end
    push_result(held_box, held_agrees_prev || agrees(held_area, area), !last);
    new_agrees_prev = agrees(area, held_area);
    if (last) begin
      push_result(b, new_agrees_prev, 1'b1);
      held_box         = '0;
      held_area        = '0;
      held_agrees_prev = 1'b0;
      held_valid       = 1'b0;
    end else begin
      held_box         = b;
      held_area        = area;
      held_agrees_prev = new_agrees_prev;
    end
  endfunction

  function void report(string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endfunction

  function void check_result(nabf_pkg::res_t got);
    nabf_pkg::res_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result x=%0d y=%0d w=%0d h=%0d keep=%0b last=%0b",
                       got.box.x, got.box.y, got.box.w, got.box.h, got.keep,
                       got.last_of_item));
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got.keep === 1'b1) kept++;
    if (got.box.x !== want.box.x || got.box.y !== want.box.y ||
        got.box.w !== want.box.w || got.box.h !== want.box.h ||
        got.keep !== want.keep || got.last_of_item !== want.last_of_item) begin
      report($sformatf(
        {"result %0d got x=%0d y=%0d w=%0d h=%0d k=%0b l=%0b",
         " want x=%0d y=%0d w=%0d h=%0d k=%0b l=%0b"},
        checked, got.box.x, got.box.y, got.box.w, got.box.h, got.keep, got.last_of_item,
        want.box.x, want.box.y, want.box.w, want.box.h, want.keep, want.last_of_item));
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

endclass

module neighbor_area_box_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 5000;
  localparam logic [nabf_pkg::CfgIdxW-1:0] CfgSpare2 = nabf_pkg::CfgIdxW'(2);
  localparam logic [nabf_pkg::CfgIdxW-1:0] CfgSpare3 = nabf_pkg::CfgIdxW'(3);

  logic clk_i;
  logic rst_ni;

  nabf_box_if box_if ();
  nabf_cfg_if cfg_if ();
  nabf_res_if res_if ();

  neighbor_area_box_filter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_i  (box_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  box_decision_board board;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       boxes_sent;
  int unsigned       lists_sent;
  int unsigned       cfg_writes;
  int unsigned       quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic nabf_pkg::box_t mk_box(int unsigned x, int unsigned y, int unsigned w,
                                            int unsigned h);
    nabf_pkg::box_t b;
    b.x = nabf_pkg::PosW'(x);
    b.y = nabf_pkg::PosW'(y);
    b.w = nabf_pkg::SideW'(w);
    b.h = nabf_pkg::SideW'(h);
    return b;
  endfunction

  function automatic nabf_pkg::box_t random_box(int unsigned bw, int unsigned bh);
    nabf_pkg::box_t b;
    int unsigned    roll;
    b.x  = nabf_pkg::PosW'($urandom);
    b.y  = nabf_pkg::PosW'($urandom);
    roll = $urandom_range(99);
    if (roll < 70) begin
      b.w = nabf_pkg::SideW'(bw * $urandom_range(1, 3) + $urandom_range(0, bw / 2));
      b.h = nabf_pkg::SideW'(bh * $urandom_range(1, 3) + $urandom_range(0, bh / 2));
    end else if (roll < 78) begin
      b.w = $urandom_range(1) ? nabf_pkg::SideW'(0) : nabf_pkg::SideW'(bw);
      b.h = (b.w == 0) ? nabf_pkg::SideW'($urandom_range(0, 50)) : nabf_pkg::SideW'(0);
    end else if (roll < 90) begin
      b.w = nabf_pkg::SideW'($urandom);
      b.h = nabf_pkg::SideW'($urandom);
    end else begin
      b.w = nabf_pkg::SideW'($urandom_range(3900, 8191));
      b.h = nabf_pkg::SideW'($urandom_range(3900, 8191));
    end
    return b;
  endfunction

  task automatic send_box(input nabf_pkg::box_t b, input bit last);
    bit done;
    while ($urandom_range(99) < idle_pct) begin
      box_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    box_if.valid      <= 1'b1;
    box_if.box_x      <= b.x;
    box_if.box_y      <= b.y;
    box_if.box_width  <= b.w;
    box_if.box_height <= b.h;
    box_if.list_last  <= last;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      done = box_if.ready;
      if (done) board.note_box(b, last);
      @(posedge clk_i);
    end
    boxes_sent++;
    if (last) lists_sent++;
  endtask

  task automatic write_reg(input logic [nabf_pkg::CfgIdxW-1:0] idx,
                           input logic [nabf_pkg::CfgDataW-1:0] data);
    bit done;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      done = cfg_if.ready;
      @(posedge clk_i);
    end
    board.write_reg(idx, data);
    cfg_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    box_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_lists(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned bw;
    int unsigned bh;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      bw  = ($urandom_range(3) == 0) ? $urandom_range(1, 1000) : $urandom_range(1, 40);
      bh  = ($urandom_range(3) == 0) ? $urandom_range(1, 1000) : $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        send_box(random_box(bw, bh), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic run_directed();
    send_box(mk_box(4095, 4095, 8191, 8191), 1'b1);
    send_box(mk_box(0, 0, 0, 0), 1'b1);
    send_box(mk_box(12, 34, 10, 10), 1'b0);
    send_box(mk_box(56, 78, 10, 10), 1'b1);
    send_box(mk_box(1, 2, 10, 10), 1'b0);
    send_box(mk_box(3, 4, 0, 10), 1'b1);
    send_box(mk_box(5, 6, 10, 10), 1'b0);
    send_box(mk_box(7, 8, 40, 40), 1'b0);
    send_box(mk_box(9, 10, 40, 40), 1'b1);
    // oversized sides clamp for the area only
    send_box(mk_box(0, 4095, 8191, 1), 1'b0);
    send_box(mk_box(4095, 0, 4096, 1), 1'b1);
    send_box(mk_box(11, 11, 5, 5), 1'b0);
    send_box(mk_box(12, 12, 5, 5), 1'b1);
    // quotient exactly at the limit, then a pair well within it
    send_box(mk_box(13, 13, 10, 10), 1'b0);
    send_box(mk_box(14, 14, 10, 50), 1'b0);
    send_box(mk_box(15, 15, 10, 49), 1'b1);
    send_box(mk_box(16, 16, 4097, 4097), 1'b0);
    send_box(mk_box(17, 17, 4096, 4096), 1'b1);
    send_box(mk_box(2730, 1365, 2730, 1365), 1'b0);
    send_box(mk_box(1365, 2730, 0, 8191), 1'b0);
    send_box(mk_box(100, 200, 6, 6), 1'b1);
    drain();
    // ratio limit zero rejects every pair
    write_reg(nabf_pkg::CfgRatioLimit, nabf_pkg::CfgDataW'(0));
    send_box(mk_box(1, 1, 20, 20), 1'b0);
    send_box(mk_box(2, 2, 20, 20), 1'b1);
    drain();
    write_reg(nabf_pkg::CfgRatioLimit, nabf_pkg::CfgDataW'(5));
  endtask

  task automatic set_phase_regs(input int unsigned p);
    case (p)
      1: begin
        write_reg(nabf_pkg::CfgRatioLimit, nabf_pkg::CfgDataW'(255));
        write_reg(nabf_pkg::CfgMinArea, nabf_pkg::CfgDataW'(0));
      end
      2: begin
        write_reg(nabf_pkg::CfgRatioLimit, nabf_pkg::CfgDataW'(1));
        write_reg(nabf_pkg::CfgMinArea, nabf_pkg::CfgDataW'(25'h1FFFFFF));
      end
      3: begin
        write_reg(nabf_pkg::CfgRatioLimit, nabf_pkg::CfgDataW'(25'h1FFFF03));
        write_reg(nabf_pkg::CfgMinArea, nabf_pkg::CfgDataW'(16777216));
      end
      4: begin
        write_reg(nabf_pkg::CfgRatioLimit, nabf_pkg::CfgDataW'(0));
        write_reg(nabf_pkg::CfgMinArea, nabf_pkg::CfgDataW'(30));
      end
      5: begin
        write_reg(nabf_pkg::CfgRatioLimit, nabf_pkg::CfgDataW'(2));
        write_reg(nabf_pkg::CfgMinArea, nabf_pkg::CfgDataW'(1));
      end
      6: begin
        write_reg(nabf_pkg::CfgRatioLimit, nabf_pkg::CfgDataW'($urandom_range(2, 20)));
        write_reg(nabf_pkg::CfgMinArea, nabf_pkg::CfgDataW'($urandom_range(0, 5000)));
      end
      7: begin
        write_reg(CfgSpare2, nabf_pkg::CfgDataW'($urandom));
        write_reg(CfgSpare3, nabf_pkg::CfgDataW'($urandom));
        write_reg(nabf_pkg::CfgRatioLimit, nabf_pkg::CfgDataW'(8));
        write_reg(nabf_pkg::CfgMinArea, nabf_pkg::CfgDataW'(200));
      end
      default: ;
    endcase
  endtask

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    nabf_pkg::res_t got;
    quiet_cycles = 0;
    forever begin
      @(negedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got.box.x        = res_if.out_x;
        got.box.y        = res_if.out_y;
        got.box.w        = res_if.out_width;
        got.box.h        = res_if.out_height;
        got.keep         = res_if.keep;
        got.last_of_item = res_if.last_of_item;
        board.check_result(got);
      end
      if ((res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
          (box_if.valid === 1'b1 && box_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("neighbor_area_box_filter verification failed");
        $finish;
      end
    end
  end

  initial begin
    board      = new();
    idle_pct   = 0;
    stall_pct  = 0;
    boxes_sent = 0;
    lists_sent = 0;
    cfg_writes = 0;
    rst_ni            <= 1'b0;
    box_if.valid      <= 1'b0;
    box_if.box_x      <= '0;
    box_if.box_y      <= '0;
    box_if.box_width  <= '0;
    box_if.box_height <= '0;
    box_if.list_last  <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 8; p++) begin
      set_phase_regs(p);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      random_lists(225);
      idle_pct  = 0;
      stall_pct = 0;
      drain();
    end
    $display("ran %0d boxes in %0d lists across eight register settings and four pacing modes",
             boxes_sent, lists_sent);
    $display("%0d results checked, %0d kept, %0d register writes, %0d mismatches",
             board.checked, board.kept, cfg_writes, board.mismatches);
    if (board.mismatches == 0) begin
      $display("neighbor_area_box_filter verification clean");
    end else begin
      $display("neighbor_area_box_filter verification failed");
    end
    $finish;
  end

endmodule
